### design/ktca_pkg.sv
// Shared constants and types for the k-ary tree common ancestor block.
package ktca_pkg;

   localparam int NODE_BITS  = 32;
   localparam int MAX_LEVELS = 33;
   localparam int ARITY_BITS = 32;
   localparam int OUT_BITS   = 32;
   localparam int LVL_BITS   = $clog2(MAX_LEVELS);
   localparam int CNT_BITS   = $clog2(NODE_BITS + 1);

   localparam logic [NODE_BITS:0]   NODE_CAP  = (NODE_BITS + 1)'(1) << NODE_BITS;
   localparam logic [LVL_BITS-1:0]  LAST_LVL  = LVL_BITS'(MAX_LEVELS - 1);
   localparam logic [CNT_BITS-1:0]  LAST_STEP = CNT_BITS'(NODE_BITS - 1);

   // Classified item handed from the front to the back
   typedef struct packed {
      logic [ARITY_BITS-1:0] arity;
      logic [NODE_BITS-1:0]  lo;
      logic [NODE_BITS-1:0]  hi;
      logic                  chain;
   } item_type;

   // Queue status seen by the back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage

### design/ktca_front.sv
// Front end: accept requests, normalize and order the nodes, queue them.
module ktca_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ktca_pkg::ARITY_BITS-1:0]     req_arity,
   input  logic [31:0]                         req_node_a,
   input  logic [31:0]                         req_node_b,
   output ktca_pkg::queue_type                 q_out,
   input  logic                                q_pop
);

   logic [ktca_pkg::NODE_BITS-1:0] a_node, b_node;
   ktca_pkg::item_type             new_item;
   ktca_pkg::item_type             slot_ff [2];
   ktca_pkg::item_type             slot_in [2];
   logic [1:0]                     cnt_ff, cnt_in;
   logic                           push;

   // Classify: zero node means root, order the pair, flag chain trees
   always_comb begin
      a_node = ktca_pkg::NODE_BITS'(req_node_a);
      b_node = ktca_pkg::NODE_BITS'(req_node_b);
      if (a_node == '0) a_node = ktca_pkg::NODE_BITS'(1);
      if (b_node == '0) b_node = ktca_pkg::NODE_BITS'(1);
      new_item.arity = req_arity;
      new_item.lo    = (a_node < b_node) ? a_node : b_node;
      new_item.hi    = (a_node < b_node) ? b_node : a_node;
      new_item.chain = (req_arity <= ktca_pkg::ARITY_BITS'(1));
   end

   assign req_stall   = (cnt_ff == 2'd2);
   assign push        = req_valid && !req_stall;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = slot_ff[0];

   // Advance the two-entry queue
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      cnt_in     = cnt_ff;
      if (q_pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) slot_in[0] = new_item;
         else                slot_in[1] = new_item;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end

endmodule

### design/ktca_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ktca_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ktca_pkg::NODE_BITS-1:0]   dividend,
   input  logic [ktca_pkg::ARITY_BITS-1:0]  divisor,
   output logic                             done,
   output logic [ktca_pkg::NODE_BITS-1:0]   quotient
);

   logic [ktca_pkg::ARITY_BITS-1:0] rem_ff, rem_in;
   logic [ktca_pkg::NODE_BITS-1:0]  quo_ff, quo_in;
   logic [ktca_pkg::ARITY_BITS-1:0] div_ff;
   logic [ktca_pkg::CNT_BITS-1:0]   cnt_ff;
   logic                            busy_ff, done_ff;
   logic [ktca_pkg::ARITY_BITS:0]   trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[ktca_pkg::NODE_BITS-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = ktca_pkg::ARITY_BITS'(trial - {1'b0, div_ff});
         quo_in = {quo_ff[ktca_pkg::NODE_BITS-2:0], 1'b1};
      end else begin
         rem_in = ktca_pkg::ARITY_BITS'(trial);
         quo_in = {quo_ff[ktca_pkg::NODE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + ktca_pkg::CNT_BITS'(1);
            if (cnt_ff == ktca_pkg::LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Load operands or step the datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

### design/ktca_back.sv
// Back end: level build, offset lifting and node rebuild sequencer.
module ktca_back (
   input  logic                           clock,
   input  logic                           reset,
   input  ktca_pkg::queue_type            q_in,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ktca_pkg::OUT_BITS-1:0]  rsp_ancestor
);

   localparam int NB = ktca_pkg::NODE_BITS;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_BUILD = 9'b000000010,
      ST_OFFS  = 9'b000000100,
      ST_LIFT  = 9'b000001000,
      ST_MEET  = 9'b000010000,
      ST_DIVB  = 9'b000100000,
      ST_DIVA  = 9'b001000000,
      ST_READ  = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   state_type                        state_ff;
   logic [ktca_pkg::ARITY_BITS-1:0]  k_ff;
   logic [NB-1:0]                    lo_ff, hi_ff, oa_ff, ob_ff, ans_ff;
   logic [NB:0]                      cum_ff, sz_ff, sa_ff, sb_ff, rd_ff;
   logic [ktca_pkg::LVL_BITS-1:0]    l_ff, la_ff, lb_ff;
   logic                             fa_ff, fb_ff, meet_ff;
   logic                             out_valid_ff;
   logic [ktca_pkg::OUT_BITS-1:0]    out_data_ff;
   logic [NB:0]                      start_mem [ktca_pkg::MAX_LEVELS];

   logic [NB+1:0]                    cum_sum;
   logic [NB:0]                      lvl_end;
   logic [NB+ktca_pkg::ARITY_BITS-1:0] prod;
   logic [NB:0]                      sz_next;
   logic                             hit_a, hit_b, out_free;
   logic                             div_start, div_done;
   logic [NB-1:0]                    div_dividend, div_quot;

   ktca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (k_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp_ancestor = out_data_ff;
   assign q_pop        = (state_ff == ST_IDLE) && q_in.valid;

   // Saturating level boundary and next level size
   always_comb begin
      cum_sum = {1'b0, cum_ff} + {1'b0, sz_ff};
      lvl_end = (cum_sum > {1'b0, ktca_pkg::NODE_CAP}) ? ktca_pkg::NODE_CAP
                                                       : (NB + 1)'(cum_sum);
      prod    = NB'(sz_ff) * k_ff;
      if (sz_ff >= ktca_pkg::NODE_CAP ||
          prod >= (NB + ktca_pkg::ARITY_BITS)'(ktca_pkg::NODE_CAP))
         sz_next = ktca_pkg::NODE_CAP;
      else
         sz_next = (NB + 1)'(prod);
      hit_a = !fa_ff && ({1'b0, lo_ff} <= lvl_end || l_ff == ktca_pkg::LAST_LVL);
      hit_b = !fb_ff && ({1'b0, hi_ff} <= lvl_end || l_ff == ktca_pkg::LAST_LVL);
   end

   // Launch divisions from the decision states
   always_comb begin
      div_start    = 1'b0;
      div_dividend = ob_ff;
      unique case (state_ff)
         ST_LIFT: div_start = (lb_ff > la_ff);
         ST_MEET: div_start = (oa_ff != ob_ff) && (l_ff != '0);
         ST_DIVB: begin
            div_start    = div_done && meet_ff;
            div_dividend = oa_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   // Level start table
   always_ff @(posedge clock) begin
      if (state_ff == ST_BUILD) start_mem[l_ff] <= cum_ff;
      rd_ff <= start_mem[l_ff];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // Load a new result or drop the one just taken
         if (state_ff == ST_FIN && out_free) out_valid_ff <= 1'b1;
         else if (!rsp_stall)                out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_in.valid) begin
                  k_ff   <= q_in.item.arity;
                  lo_ff  <= q_in.item.lo;
                  hi_ff  <= q_in.item.hi;
                  ans_ff <= q_in.item.lo;
                  cum_ff <= '0;
                  sz_ff  <= (NB + 1)'(1);
                  l_ff   <= '0;
                  fa_ff  <= 1'b0;
                  fb_ff  <= 1'b0;
                  state_ff <= q_in.item.chain ? ST_FIN : ST_BUILD;
               end
            end
            ST_BUILD: begin
               if (hit_a) begin
                  fa_ff <= 1'b1;
                  la_ff <= l_ff;
                  sa_ff <= cum_ff;
               end
               if (hit_b) begin
                  fb_ff <= 1'b1;
                  lb_ff <= l_ff;
                  sb_ff <= cum_ff;
               end
               cum_ff <= lvl_end;
               sz_ff  <= sz_next;
               l_ff   <= l_ff + ktca_pkg::LVL_BITS'(1);
               if (l_ff == ktca_pkg::LAST_LVL) state_ff <= ST_OFFS;
            end
            ST_OFFS: begin
               oa_ff    <= NB'({1'b0, lo_ff} - (NB + 1)'(1) - sa_ff);
               ob_ff    <= NB'({1'b0, hi_ff} - (NB + 1)'(1) - sb_ff);
               state_ff <= ST_LIFT;
            end
            ST_LIFT: begin
               meet_ff <= 1'b0;
               if (lb_ff > la_ff) begin
                  state_ff <= ST_DIVB;
               end else begin
                  l_ff     <= la_ff;
                  state_ff <= ST_MEET;
               end
            end
            ST_MEET: begin
               meet_ff <= 1'b1;
               if ((oa_ff != ob_ff) && (l_ff != '0)) begin
                  state_ff <= ST_DIVB;
               end else if (l_ff == '0) begin
                  ans_ff   <= NB'(1);
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_DIVB: begin
               if (div_done) begin
                  ob_ff <= div_quot;
                  if (meet_ff) begin
                     state_ff <= ST_DIVA;
                  end else begin
                     lb_ff    <= lb_ff - ktca_pkg::LVL_BITS'(1);
                     state_ff <= ST_LIFT;
                  end
               end
            end
            ST_DIVA: begin
               if (div_done) begin
                  oa_ff    <= div_quot;
                  l_ff     <= l_ff - ktca_pkg::LVL_BITS'(1);
                  state_ff <= ST_MEET;
               end
            end
            ST_READ: begin
               ans_ff   <= NB'(rd_ff + {1'b0, oa_ff} + (NB + 1)'(1));
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Hold result data until taken
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && out_free)
         out_data_ff <= ktca_pkg::OUT_BITS'(ans_ff);
   end

endmodule

### design/kary_tree_common_ancestor.sv
// Top level of the k-ary tree lowest common ancestor block.
// Request channel (req_): arity and two one-based breadth-first node numbers,
// taken when req_valid is high and req_stall is low. A two-entry queue sits
// behind the request port, so requests are taken while the back end works.
// Response channel (rsp_): one ancestor number per request, in order, held
// in an output register until a cycle with rsp_stall low.
// Arity 0 or 1 goes from the queue through the idle and finish states to
// the output register. Other arities build the level boundaries for all
// MAX_LEVELS levels, compute the offsets, lift the deeper node one level
// per division on the shared iterative divider, with a decision state
// between divisions, then lift both nodes, two divisions per level, until
// they meet and, unless that is at the root, read the level start table.
// The divider sets the rate.
// Items are processed one at a time in the back end.
// Reset (synchronous, active high) empties the queue, returns the sequencer
// to idle and drops rsp_valid. While rsp_stall is high the result holds and
// the back end waits with its next result; the queue keeps taking requests until full.
module kary_tree_common_ancestor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_arity,
   input  logic [31:0] req_node_a,
   input  logic [31:0] req_node_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_ancestor
);

   ktca_pkg::queue_type q_link;
   logic                q_pop;

   ktca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_arity  (req_arity),
      .req_node_a (req_node_a),
      .req_node_b (req_node_b),
      .q_out      (q_link),
      .q_pop      (q_pop)
   );

   ktca_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_in         (q_link),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ancestor (rsp_ancestor)
   );

   // Reset leaves both channels quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not quiet after reset");

   // Ancestor number is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ancestor != 32'd0)
      else $error("zero ancestor returned");

   // Pop only from a non-empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_link.valid)
      else $error("pop from empty queue");

   // Stalled result stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ancestor))
      else $error("stalled result dropped");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the k-ary tree lowest common ancestor block.
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 250;
   localparam int SETTLE_CYCLES  = 60;

   typedef struct {
      logic [31:0] arity;
      logic [31:0] node_a;
      logic [31:0] node_b;
      logic [31:0] ancestor;
      bit          known;
   } lca_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_arity = '0;
   logic [31:0] req_node_a = '0;
   logic [31:0] req_node_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_ancestor;

   logic [31:0] ancestor_queue[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   bit          quiet_phase = 1'b0;
   lca_row_type directed_rows[$];

   kary_tree_common_ancestor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_arity(req_arity), .req_node_a(req_node_a), .req_node_b(req_node_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_ancestor(rsp_ancestor)
   );

   always #5 clock = ~clock;

   // Compute the lowest common ancestor with saturating level boundaries
   function automatic logic [31:0] lowest_ancestor(logic [31:0] arity,
                                                   logic [31:0] node_a,
                                                   logic [31:0] node_b);
      logic [63:0] cap;
      logic [63:0] k, a, b, lo, hi, cum, sz, oa, ob;
      logic [63:0] lvl_first[ktca_pkg::MAX_LEVELS];
      logic [63:0] lvl_last[ktca_pkg::MAX_LEVELS];
      int          la, lb, l;
      cap = 64'd1 << ktca_pkg::NODE_BITS;
      k = {32'd0, arity};
      a = {32'd0, node_a};
      b = {32'd0, node_b};
      if (a == 0) a = 1;
      if (b == 0) b = 1;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (k <= 1) return lo[31:0];
      cum = 0;
      sz = 1;
      for (int i = 0; i < ktca_pkg::MAX_LEVELS; i++) begin
         lvl_first[i] = cum;
         cum = (cum + sz > cap) ? cap : cum + sz;
         lvl_last[i] = cum;
         sz = (sz > cap / k) ? cap : sz * k;
      end
      la = ktca_pkg::MAX_LEVELS - 1;
      for (int i = ktca_pkg::MAX_LEVELS - 1; i >= 0; i--) if (lo <= lvl_last[i]) la = i;
      lb = ktca_pkg::MAX_LEVELS - 1;
      for (int i = ktca_pkg::MAX_LEVELS - 1; i >= 0; i--) if (hi <= lvl_last[i]) lb = i;
      oa = lo - 1 - lvl_first[la];
      ob = hi - 1 - lvl_first[lb];
      // lift the deeper node, then both until they meet
      while (lb > la) begin
         ob = ob / k;
         lb--;
      end
      l = la;
      while (oa != ob && l > 0) begin
         oa = oa / k;
         ob = ob / k;
         l--;
      end
      if (l == 0) return 32'd1;
      return 32'(lvl_first[l] + oa + 1);
   endfunction

   // Record the expected ancestor on every request transfer; check responses
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_valid && !req_stall)
            ancestor_queue = {ancestor_queue,
                              lowest_ancestor(req_arity, req_node_a, req_node_b)};
         if (rsp_valid && !rsp_stall) begin
            if (ancestor_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: ancestor %0d", rsp_ancestor);
            end else begin
               want = ancestor_queue.pop_front();
               if (rsp_ancestor !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ancestor mismatch: expected %0d, got %0d", want, rsp_ancestor);
               end
            end
         end
         // watchdog on cycles with no transfer at all
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Stall the response side at random, with quiet stretches
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset || quiet_phase)
         rsp_stall <= 1'b0;
      else if (rsp_stall)
         rsp_stall <= (r < 70) ? 1'b1 : 1'b0;
      else
         rsp_stall <= (r < 15) ? 1'b1 : 1'b0;
   end

   // Drive one request and hold it until the transfer
   task automatic send_request(logic [31:0] arity, logic [31:0] node_a, logic [31:0] node_b);
      int gap, r;
      req_valid  <= 1'b1;
      req_arity  <= arity;
      req_node_a <= node_a;
      req_node_b <= node_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_node();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 32'd0;
      if (r < 40) return $urandom_range(1, 1000);
      if (r < 60) return $urandom_range(1, 100000);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_arity();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 1);
      if (r < 55) return $urandom_range(2, 16);
      if (r < 75) return $urandom_range(17, 65536);
      return $urandom;
   endfunction

   function automatic void add_row(logic [31:0] k, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] anc, bit known);
      lca_row_type row;
      row.arity = k;
      row.node_a = a;
      row.node_b = b;
      row.ancestor = anc;
      row.known = known;
      directed_rows = {directed_rows, row};
   endfunction

   initial begin
      logic [31:0] k, a, b;
      // chains, node zero, extremes, siblings, same node
      add_row(32'd1, 32'd7, 32'd3, 32'd3, 1);
      add_row(32'd0, 32'd9, 32'd12, 32'd9, 1);
      add_row(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1);
      add_row(32'd1, 32'd0, 32'd5, 32'd1, 1);
      add_row(32'd2, 32'd0, 32'd0, 32'd1, 1);
      add_row(32'd2, 32'd2, 32'd3, 32'd1, 1);
      add_row(32'd2, 32'd4, 32'd5, 32'd2, 1);
      add_row(32'd3, 32'd5, 32'd7, 32'd2, 1);
      add_row(32'd2, 32'd1, 32'hFFFF_FFFF, 32'd1, 1);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 1);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 0);
      add_row(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 0);
      add_row(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0);
      add_row(32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 0);
      add_row(32'd3, 32'd100, 32'd12345, 32'd0, 0);
      add_row(32'd4, 32'd21, 32'd86, 32'd0, 0);
      add_row(32'h8000_0000, 32'h8000_0001, 32'h8000_0002, 32'd0, 0);
      add_row(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0002, 32'd0, 0);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 0);
      add_row(32'd7, 32'd1000, 32'd1000, 32'd0, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known &&
             lowest_ancestor(directed_rows[i].arity, directed_rows[i].node_a,
                             directed_rows[i].node_b) !== directed_rows[i].ancestor) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("row %0d: expected %0d", i, directed_rows[i].ancestor);
         end
         send_request(directed_rows[i].arity, directed_rows[i].node_a,
                      directed_rows[i].node_b);
      end

      // random part: half nearby node pairs, half independently picked ones
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         k = pick_arity();
         a = pick_node();
         if ($urandom_range(0, 1)) b = a + $urandom_range(0, 64);
         else b = pick_node();
         send_request(k, a, b);
      end
      req_valid <= 1'b0;

      // drain, then settle
      while (ancestor_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
